[sv/wis_pkg.sv]
package wis_pkg;

  localparam int unsigned PriorW  = 32;
  localparam int unsigned WeightW = 23;
  localparam int unsigned CvW     = 48;
  localparam int unsigned CwW     = 40;
  localparam int unsigned NumW    = CvW + 2;
  localparam int unsigned DvdW    = NumW - 1 + 16;
  localparam int unsigned OutW    = 31;
  localparam logic [WeightW-1:0] WeightMax = 23'd6553600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RDI,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_RDS,
    ST_CMP,
    ST_RDLO,
    ST_FILL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_cap;
    logic load_wr;
    logic cmp_init;
    logic rd_i;
    logic div_start;
    logic rd_s;
    logic dec_j;
    logic rd_lo;
    logic fill_init;
    logic fill_wr;
    logic next_i;
    logic out_init;
    logic out_rd;
  } cmd_t;

  typedef struct packed {
    logic set_end;
    logic div_done;
    logic j_gt1;
    logic viol;
    logic fill_end;
    logic i_last;
    logic out_end;
  } stat_t;

endpackage

[sv/wis_div.sv]
module wis_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [wis_pkg::NumW-1:0] num_i,
  input  logic [wis_pkg::CwW-1:0]         den_i,
  output logic                            done_o,
  output logic signed [wis_pkg::CvW-1:0]  quo_o
);

  localparam int unsigned DvdW = wis_pkg::DvdW;
  localparam int unsigned CwW  = wis_pkg::CwW;
  localparam int unsigned CvW  = wis_pkg::CvW;
  localparam int unsigned NumW = wis_pkg::NumW;

  logic            busy_q, busy_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [CwW-1:0]  rem_q, rem_d;
  logic [CwW-1:0]  den_q, den_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;

  logic [NumW-1:0] mag;
  logic [CwW:0]    shifted;
  logic [CwW:0]    diff;
  logic            big;

  assign mag     = num_i[NumW-1] ? (~num_i + 1'b1) : num_i;
  assign shifted = {rem_q, dvd_q[DvdW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'(DvdW);
      dvd_d  = {mag[NumW-2:0], 16'd0};
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[NumW-1];
    end else if (busy_q) begin
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      if (!diff[CwW]) begin
        rem_d = diff[CwW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[CwW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // saturate to the signed 48-bit range
  assign big = |quo_q[DvdW-1:CvW-1];
  always_comb begin
    if (neg_q) begin
      quo_o = big ? {1'b1, {(CvW-1){1'b0}}} : -$signed({1'b0, quo_q[CvW-2:0]});
    end else begin
      quo_o = big ? {1'b0, {(CvW-1){1'b1}}} : $signed({1'b0, quo_q[CvW-2:0]});
    end
  end

  assign done_o = done_q;

endmodule

[sv/wis_ctrl.sv]
module wis_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wis_pkg::stat_t stat_i,
  output wis_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  wis_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wis_pkg::ST_IDLE:    if (start_i) state_d = wis_pkg::ST_LOAD;
      wis_pkg::ST_LOAD:    state_d = stat_i.set_end ? wis_pkg::ST_RDI : wis_pkg::ST_IDLE;
      wis_pkg::ST_RDI:     state_d = wis_pkg::ST_DIVGO;
      wis_pkg::ST_DIVGO:   state_d = wis_pkg::ST_DIVWAIT;
      wis_pkg::ST_DIVWAIT: begin
        if (stat_i.div_done) state_d = stat_i.j_gt1 ? wis_pkg::ST_RDS : wis_pkg::ST_FILL;
      end
      wis_pkg::ST_RDS:     state_d = wis_pkg::ST_CMP;
      wis_pkg::ST_CMP:     state_d = stat_i.viol ? wis_pkg::ST_RDLO : wis_pkg::ST_FILL;
      wis_pkg::ST_RDLO:    state_d = wis_pkg::ST_DIVGO;
      wis_pkg::ST_FILL: begin
        if (stat_i.fill_end) state_d = stat_i.i_last ? wis_pkg::ST_OUT : wis_pkg::ST_RDI;
      end
      wis_pkg::ST_OUT:     if (stat_i.out_end) state_d = wis_pkg::ST_IDLE;
      default:             state_d = wis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      wis_pkg::ST_IDLE: begin
        busy_o         = 1'b0;
        cmd_o.load_cap = start_i;
      end
      wis_pkg::ST_LOAD: begin
        cmd_o.load_wr  = 1'b1;
        cmd_o.cmp_init = stat_i.set_end;
      end
      wis_pkg::ST_RDI:   cmd_o.rd_i = 1'b1;
      wis_pkg::ST_DIVGO: cmd_o.div_start = 1'b1;
      wis_pkg::ST_DIVWAIT: begin
        cmd_o.fill_init = stat_i.div_done & ~stat_i.j_gt1;
      end
      wis_pkg::ST_RDS:   cmd_o.rd_s = 1'b1;
      wis_pkg::ST_CMP: begin
        cmd_o.dec_j     = stat_i.viol;
        cmd_o.fill_init = ~stat_i.viol;
      end
      wis_pkg::ST_RDLO:  cmd_o.rd_lo = 1'b1;
      wis_pkg::ST_FILL: begin
        cmd_o.fill_wr  = 1'b1;
        cmd_o.next_i   = stat_i.fill_end;
        cmd_o.out_init = stat_i.fill_end & stat_i.i_last;
      end
      wis_pkg::ST_OUT:   cmd_o.out_rd = 1'b1;
      default:           busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/wis_dp.sv]
module wis_dp #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wis_pkg::cmd_t                      cmd_i,
  output wis_pkg::stat_t                     stat_o,
  input  logic signed [wis_pkg::PriorW-1:0]  prior_value_i,
  input  logic [wis_pkg::WeightW-1:0]        weight_i,
  input  logic signed [wis_pkg::PriorW-1:0]  gradient_i,
  input  logic                               last_point_i,
  output logic                               result_valid_o,
  output logic [wis_pkg::OutW-1:0]           fitted_value_o,
  output logic                               last_result_o
);

  localparam int unsigned CvW  = wis_pkg::CvW;
  localparam int unsigned CwW  = wis_pkg::CwW;
  localparam int unsigned NumW = wis_pkg::NumW;
  localparam int unsigned WW   = wis_pkg::WeightW;
  localparam int unsigned PW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned PrW  = wis_pkg::PriorW + WW + 1;

  logic signed [CvW-1:0] cv_mem [MAX_POINTS];
  logic [CwW-1:0]        cw_mem [MAX_POINTS];
  logic signed [CvW-1:0] sl_mem [MAX_POINTS];

  logic signed [PrW-1:0]            prod_q;
  logic signed [wis_pkg::PriorW-1:0] grad_q;
  logic [WW-1:0]                    w_q;
  logic                             last_q;
  logic signed [CvW-1:0]            run_cv_q;
  logic [CwW-1:0]                   run_cw_q;
  logic [PW-1:0]                    cnt_q, n_q, i_q, j_q, f_q, k_q;
  logic signed [CvW-1:0]            cv_hi_q, cv_lo_q, s_q, sv_q, ov_q;
  logic [CwW-1:0]                   cw_hi_q, cw_lo_q;
  logic                             ovld_q, olast_q;

  logic [WW-1:0]         w_cl;
  logic signed [NumW-1:0] sum;
  logic signed [CvW-1:0]  sum_sat;
  logic signed [NumW-1:0] num;
  logic [CwW-1:0]         den;
  logic                   div_done;
  logic signed [CvW-1:0]  quo;
  logic [PW-1:0]          cnt_nx;

  always_comb begin
    if (weight_i == '0) w_cl = WW'(1);
    else if (weight_i > wis_pkg::WeightMax) w_cl = wis_pkg::WeightMax;
    else w_cl = weight_i;
  end

  assign sum = NumW'(run_cv_q) + NumW'(prod_q >>> 16) - NumW'(grad_q);
  always_comb begin
    if (sum > NumW'(signed'({1'b0, {(CvW-1){1'b1}}}))) sum_sat = {1'b0, {(CvW-1){1'b1}}};
    else if (sum < -(NumW'(signed'({1'b0, {(CvW-1){1'b1}}})) + NumW'(1)))
      sum_sat = {1'b1, {(CvW-1){1'b0}}};
    else sum_sat = sum[CvW-1:0];
  end

  assign cnt_nx = cnt_q + PW'(1);
  assign num    = NumW'(cv_hi_q) - NumW'(cv_lo_q);
  assign den    = cw_hi_q - cw_lo_q;

  wis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // load path: register the product, then accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cap) begin
      prod_q <= $signed(prior_value_i) * $signed({1'b0, w_cl});
      grad_q <= gradient_i;
      w_q    <= w_cl;
      last_q <= last_point_i;
    end
    if (cmd_i.load_wr) begin
      cv_mem[cnt_q[AW-1:0]] <= sum_sat;
      cw_mem[cnt_q[AW-1:0]] <= run_cw_q + CwW'(w_q);
    end
    if (cmd_i.rd_i) begin
      cv_hi_q <= cv_mem[AW'(i_q - PW'(1))];
      cw_hi_q <= cw_mem[AW'(i_q - PW'(1))];
      if (i_q == PW'(1)) begin
        cv_lo_q <= '0;
        cw_lo_q <= '0;
      end else begin
        cv_lo_q <= cv_mem[AW'(i_q - PW'(2))];
        cw_lo_q <= cw_mem[AW'(i_q - PW'(2))];
      end
    end
    if (cmd_i.rd_lo) begin
      if (j_q == PW'(1)) begin
        cv_lo_q <= '0;
        cw_lo_q <= '0;
      end else begin
        cv_lo_q <= cv_mem[AW'(j_q - PW'(2))];
        cw_lo_q <= cw_mem[AW'(j_q - PW'(2))];
      end
    end
    if (div_done) s_q <= quo;
    if (cmd_i.rd_s) sv_q <= sl_mem[AW'(j_q - PW'(2))];
    if (cmd_i.fill_wr) sl_mem[AW'(f_q)] <= s_q;
    if (cmd_i.out_rd) begin
      ov_q    <= sl_mem[AW'(k_q)];
      olast_q <= (k_q == n_q - PW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cv_q <= '0;
      run_cw_q <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      f_q      <= '0;
      k_q      <= '0;
      ovld_q   <= 1'b0;
    end else begin
      ovld_q <= cmd_i.out_rd;
      // the closing point empties the running sums for the next set
      if (cmd_i.cmp_init) begin
        n_q      <= cnt_nx;
        i_q      <= PW'(1);
        cnt_q    <= '0;
        run_cv_q <= '0;
        run_cw_q <= '0;
      end else if (cmd_i.load_wr) begin
        run_cv_q <= sum_sat;
        run_cw_q <= run_cw_q + CwW'(w_q);
        cnt_q    <= cnt_nx;
      end
      if (cmd_i.rd_i) j_q <= i_q;
      if (cmd_i.dec_j) j_q <= j_q - PW'(1);
      if (cmd_i.fill_init) f_q <= j_q - PW'(1);
      else if (cmd_i.fill_wr) f_q <= f_q + PW'(1);
      if (cmd_i.next_i) i_q <= i_q + PW'(1);
      if (cmd_i.out_init) k_q <= '0;
      else if (cmd_i.out_rd) k_q <= k_q + PW'(1);
    end
  end

  assign stat_o.set_end  = last_q || (cnt_nx == PW'(MAX_POINTS));
  assign stat_o.div_done = div_done;
  assign stat_o.j_gt1    = (j_q > PW'(1));
  assign stat_o.viol     = (sv_q > s_q);
  assign stat_o.fill_end = (f_q == i_q - PW'(1));
  assign stat_o.i_last   = (i_q == n_q);
  assign stat_o.out_end  = (k_q == n_q - PW'(1));

  // clamp to the unsigned 31-bit output range
  always_comb begin
    if (ov_q[CvW-1]) fitted_value_o = '0;
    else if (|ov_q[CvW-2:wis_pkg::OutW]) fitted_value_o = '1;
    else fitted_value_o = ov_q[wis_pkg::OutW-1:0];
  end

  assign result_valid_o = ovld_q;
  assign last_result_o  = olast_q;

endmodule

[sv/weighted_isotonic_step_top.sv]
// Loading: one point per start beat; busy_o is raised in LOAD after each beat.
// After the closing point busy_o stays high; a slope takes an operand read, launch,
// 65 divide steps and done, then a compare with the previous slope if there is one,
// then one write per slot; each backward pooling step adds a read, divide, compare.
// Results then leave one per cycle on result_valid_o; the receiver cannot stall.
// Asynchronous active-low reset empties the set and returns the controller to idle.
module weighted_isotonic_step_top #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [wis_pkg::PriorW-1:0]  prior_value_i,
  input  logic [wis_pkg::WeightW-1:0]        weight_i,
  input  logic signed [wis_pkg::PriorW-1:0]  gradient_i,
  input  logic                               last_point_i,
  output logic                               result_valid_o,
  output logic [wis_pkg::OutW-1:0]           fitted_value_o,
  output logic                               last_result_o
);

  wis_pkg::cmd_t  cmd;
  wis_pkg::stat_t stat;

  wis_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  wis_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .prior_value_i  (prior_value_i),
    .weight_i       (weight_i),
    .gradient_i     (gradient_i),
    .last_point_i   (last_point_i),
    .result_valid_o (result_valid_o),
    .fitted_value_o (fitted_value_o),
    .last_result_o  (last_result_o)
  );

endmodule

[sim/wis_fit_checker.sv]
`timescale 1ns / 1ps

module wis_fit_checker #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic signed [wis_pkg::PriorW-1:0]  prior_value_i,
  input  logic [wis_pkg::WeightW-1:0]        weight_i,
  input  logic signed [wis_pkg::PriorW-1:0]  gradient_i,
  input  logic                               last_point_i,
  input  logic                               result_valid_i,
  input  logic [wis_pkg::OutW-1:0]           fitted_value_i,
  input  logic                               last_result_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 fits_seen_o
);

  localparam longint S48Max = 64'sd140737488355327;
  localparam longint S48Min = -64'sd140737488355327 - 1;

  typedef struct {
    logic [wis_pkg::OutW-1:0] fit;
    logic                     last;
  } fit_t;

  fit_t   fit_q[$];
  longint sum_acc[MAX_POINTS+1];
  longint wgt_acc[MAX_POINTS+1];
  longint slopes[MAX_POINTS];
  int     n_loaded;

  function automatic longint clip48(longint v);
    if (v > S48Max) return S48Max;
    if (v < S48Min) return S48Min;
    return v;
  endfunction

  // trunc(num * 2^16 / den), saturated
  function automatic longint slope_of(longint num, longint den);
    longint a;
    longint r;
    a = num / den;
    r = num % den;
    if (a > 64'sd2147483648) return S48Max;
    if (a < -64'sd2147483648) return S48Min;
    return clip48(a * 65536 + (r * 65536) / den);
  endfunction

  task automatic fit_set(int n);
    longint s;
    longint v;
    fit_t   e;
    int     j;
    slopes[0] = slope_of(sum_acc[1], wgt_acc[1]);
    for (int i = 2; i <= n; i++) begin
      s = slope_of(sum_acc[i] - sum_acc[i-1], wgt_acc[i] - wgt_acc[i-1]);
      j = i;
      // pool backward while an earlier block is steeper
      while (j > 1 && slopes[j-2] > s) begin
        j--;
        s = slope_of(sum_acc[i] - sum_acc[j-1], wgt_acc[i] - wgt_acc[j-1]);
        for (int m = j; m < i; m++) slopes[m-1] = s;
      end
      slopes[i-1] = s;
    end
    for (int k = 0; k < n; k++) begin
      v = slopes[k];
      if (v < 0) v = 0;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      e.fit  = v[wis_pkg::OutW-1:0];
      e.last = (k == n - 1);
      fit_q.push_back(e);
    end
  endtask

  task automatic load_point(logic signed [31:0] pv, logic [22:0] wi, logic signed [31:0] gr,
                            logic lst);
    longint w;
    longint p;
    w = longint'(wi);
    if (w < 1) w = 1;
    if (w > longint'(wis_pkg::WeightMax)) w = longint'(wis_pkg::WeightMax);
    p = longint'(pv) * w;
    n_loaded++;
    sum_acc[n_loaded] = clip48(sum_acc[n_loaded-1] + (p >>> 16) - longint'(gr));
    wgt_acc[n_loaded] = wgt_acc[n_loaded-1] + w;
    if (lst || n_loaded >= MAX_POINTS) begin
      fit_set(n_loaded);
      n_loaded = 0;
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    fits_seen_o  = 0;
    n_loaded     = 0;
    sum_acc[0]   = 0;
    wgt_acc[0]   = 0;
  end

  assign pending_o = fit_q.size();

  always @(posedge clk_i) begin
    fit_t e;
    if (rst_ni) begin
      if (result_valid_i) begin
        fits_seen_o++;
        if (fit_q.size() == 0) begin
          report("unexpected fit", fitted_value_i, 0);
        end else begin
          e = fit_q.pop_front();
          if (fitted_value_i !== e.fit) report("fitted_value", fitted_value_i, e.fit);
          if (last_result_i !== e.last) report("last_result", last_result_i, e.last);
        end
      end
      if (start_i && !busy_i) begin
        load_point(prior_value_i, weight_i, gradient_i, last_point_i);
      end
    end
  end

endmodule

[sim/tb_weighted_isotonic_step_top.sv]
`timescale 1ns / 1ps

module tb_weighted_isotonic_step_top;

  localparam int unsigned MaxPoints = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic signed [31:0] prior_value_i;
  logic [22:0] weight_i;
  logic signed [31:0] gradient_i;
  logic        last_point_i;
  logic        result_valid_o;
  logic [30:0] fitted_value_o;
  logic        last_result_o;
  int          fail_count;
  int          pending;
  int          fits_seen;
  int          idle_pct;
  int          points_sent;
  int          sets_sent;

  weighted_isotonic_step_top #(.MAX_POINTS(MaxPoints)) i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .prior_value_i, .weight_i, .gradient_i,
    .last_point_i, .result_valid_o, .fitted_value_o, .last_result_o
  );

  wis_fit_checker #(.MAX_POINTS(MaxPoints)) i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .prior_value_i, .weight_i,
    .gradient_i, .last_point_i, .result_valid_i(result_valid_o),
    .fitted_value_i(fitted_value_o), .last_result_i(last_result_o),
    .fail_count_o(fail_count), .pending_o(pending), .fits_seen_o(fits_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // one beat: hold start until accepted, then drop it; the block is busy the cycle after
  task automatic send_point(logic signed [31:0] pv, logic [22:0] w, logic signed [31:0] gr,
                            logic lst);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    prior_value_i <= pv;
    weight_i      <= w;
    gradient_i    <= gr;
    last_point_i  <= lst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    start_i <= 1'b0;
    points_sent++;
    if (lst) sets_sent++;
  endtask

  function automatic logic [22:0] rand_weight();
    case ($urandom_range(5, 0))
      0: return 23'($urandom_range(3, 0));
      1: return 23'($urandom_range(23'h7fffff, 6553590));
      2: return 23'($urandom);
      default: return 23'($urandom_range(6553600, 1));
    endcase
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(5, 0))
      0: return $urandom;
      1: return 32'($signed($urandom_range(400000, 0)) - 200000);
      2: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000000, 0)) - 65536);
    endcase
  endfunction

  task automatic send_set(int n);
    for (int k = 1; k <= n; k++) begin
      send_point(rand_q16(), rand_weight(), rand_q16(), k == n);
    end
  endtask

  initial begin
    int n;
    int guard;
    start_i       = 1'b0;
    prior_value_i = '0;
    weight_i      = '0;
    gradient_i    = '0;
    last_point_i  = 1'b0;
    idle_pct      = 0;
    points_sent   = 0;
    sets_sent     = 0;
    rst_ni        = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, single point, decreasing run that pools, weight clamps
    send_point(32'h7fffffff, 23'd6553600, 32'h80000000, 1'b1);
    send_point(32'h80000000, 23'd1, 32'h7fffffff, 1'b1);
    send_point(32'h00030000, 23'd0, 32'h0, 1'b0);
    send_point(32'h00020000, 23'h7fffff, 32'h0, 1'b0);
    send_point(32'h00010000, 23'd65536, 32'h0, 1'b0);
    send_point(32'h0, 23'd65536, 32'h00010000, 1'b1);
    send_point(32'h0, 23'd1, 32'h80000000, 1'b0);
    send_point(32'h7fffffff, 23'd1, 32'h0, 1'b1);
    for (int k = 0; k < 4; k++) begin
      send_point(32'h00100000, 23'd65536, 32'h0, 1'b0);
    end
    send_point(32'hfff00000, 23'd65536, 32'h0, 1'b1);

    // hold off until the directed fits are all out
    guard = 0;
    while (pending != 0 && guard < 400000) begin
      @(negedge clk_i);
      guard++;
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : ((phase == 1) ? 65 : 0);
      // random sets, mostly short; some fill the set to end it by count
      while (points_sent < 25 + (phase + 1) * 80) begin
        case ($urandom_range(9, 0))
          0: n = MaxPoints;
          1, 2: n = $urandom_range(16, 5);
          default: n = $urandom_range(4, 1);
        endcase
        if (phase == 1 && sets_sent % 7 == 0) n = MaxPoints;
        if (n == MaxPoints) begin
          for (int k = 0; k < MaxPoints; k++) begin
            send_point(rand_q16(), rand_weight(), rand_q16(), 1'b0);
          end
        end else begin
          send_set(n);
        end
        if ($urandom_range(3, 0) == 0) begin
          // pause until every fit of the set is out
          guard = 0;
          while (pending != 0 && guard < 400000) begin
            @(negedge clk_i);
            guard++;
          end
        end
      end
    end

    guard = 0;
    while (pending != 0 && guard < 400000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (200) @(negedge clk_i);
    $display("covered %0d points in %0d marked sets, %0d fits checked",
             points_sent, sets_sent, fits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
